@@ sv/wrv_pkg.sv @@
package wrv_pkg;

  // Width of the internal byte offset counters
  localparam int OFFSET_BITS = 48;
  // Width of the offset shown on the result port
  localparam int VEND_W = 48;

  // Commit record body: type byte plus four CRC bytes
  localparam logic [31:0] COMMIT_BODY_LEN = 32'd5;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

  // Configuration register indexes
  localparam logic REG_DATA_TYPE   = 1'b0;
  localparam logic REG_COMMIT_TYPE = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_COMMIT  = 2'd2;
  localparam logic [1:0] EV_END     = 2'd3;

  // End-of-log causes
  localparam logic [2:0] CAUSE_CLEAN     = 3'd0;
  localparam logic [2:0] CAUSE_TRUNCATED = 3'd1;
  localparam logic [2:0] CAUSE_ZERO_LEN  = 3'd2;
  localparam logic [2:0] CAUSE_BAD_LEN   = 3'd3;
  localparam logic [2:0] CAUSE_CRC       = 3'd4;
  localparam logic [2:0] CAUSE_TYPE      = 3'd5;

  typedef enum logic [7:0] {
    PH_LEN         = 8'b0000_0001,
    PH_TYPE        = 8'b0000_0010,
    PH_PAYLOAD     = 8'b0000_0100,
    PH_CRC         = 8'b0000_1000,
    PH_HALT_ZERO   = 8'b0001_0000,
    PH_HALT_BADLEN = 8'b0010_0000,
    PH_HALT_CRC    = 8'b0100_0000,
    PH_HALT_TYPE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [31:0]       payload_length;
    logic [7:0]        payload_value;
    logic              record_done;
    logic [VEND_W-1:0] verified_end;
    logic [2:0]        stop_cause;
    logic              last_of_run;
  } res_t;

  // Up to two result words produced by one log byte
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // Reflected CRC-32, one byte folded in
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Offset as shown on the result port
  function automatic logic [VEND_W-1:0] vend_view(input logic [OFFSET_BITS-1:0] off);
    logic [63:0] wide;
    wide = 64'(off);
    return wide[VEND_W-1:0];
  endfunction

endpackage

@@ sv/wrv_parser.sv @@
module wrv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [7:0]          log_byte,
  input  logic                final_byte,
  output wrv_pkg::push_t      push
);

  logic [7:0]                      data_type_code;
  logic [7:0]                      commit_type_code;
  wrv_pkg::phase_t                 phase, phase_next, phase_step;
  logic [1:0]                      field_byte_count, field_byte_count_next;
  logic [31:0]                     length_accumulator, length_accumulator_next;
  logic [31:0]                     bytes_left, bytes_left_next;
  logic [wrv_pkg::OFFSET_BITS-1:0] position, position_next;
  logic [wrv_pkg::OFFSET_BITS-1:0] last_valid_end, last_valid_end_next;
  logic [31:0]                     running_crc, running_crc_next;
  logic [31:0]                     stored_crc, stored_crc_next;

  logic [31:0]     crc_fed;
  logic [31:0]     len_merged;
  logic [31:0]     crc_merged;
  logic [31:0]     left_dec;
  logic [31:0]     start_len;
  logic            prim_valid;
  wrv_pkg::res_t   prim;
  wrv_pkg::res_t   fin_res;
  logic [2:0]      cause;

  assign crc_fed    = wrv_pkg::crc_byte(running_crc, log_byte);
  assign len_merged = ((field_byte_count == 2'd0) ? 32'd0 : length_accumulator)
                    | (32'(log_byte) << {field_byte_count, 3'b000});
  assign crc_merged = stored_crc | (32'(log_byte) << {field_byte_count, 3'b000});
  assign left_dec   = bytes_left - 32'd1;
  assign start_len  = length_accumulator - 32'd1;

  // Advance the record parser by one byte
  always_comb begin
    phase_step              = phase;
    field_byte_count_next   = field_byte_count;
    length_accumulator_next = length_accumulator;
    bytes_left_next         = bytes_left;
    last_valid_end_next     = last_valid_end;
    running_crc_next        = running_crc;
    stored_crc_next         = stored_crc;
    position_next           = position + wrv_pkg::OFFSET_BITS'(1);
    prim_valid              = 1'b0;
    prim                    = '0;
    unique case (phase)
      wrv_pkg::PH_LEN: begin
        running_crc_next        = crc_fed;
        length_accumulator_next = len_merged;
        field_byte_count_next   = field_byte_count + 2'd1;
        if (field_byte_count == 2'd3) begin
          phase_step = (len_merged == 32'd0) ? wrv_pkg::PH_HALT_ZERO : wrv_pkg::PH_TYPE;
        end
      end
      wrv_pkg::PH_TYPE: begin
        running_crc_next = crc_fed;
        priority if (log_byte == data_type_code) begin
          bytes_left_next     = start_len;
          prim_valid          = 1'b1;
          prim.event_res      = wrv_pkg::EV_START;
          prim.payload_length = start_len;
          prim.record_done    = (start_len == 32'd0);
          phase_step = (start_len != 32'd0) ? wrv_pkg::PH_PAYLOAD : wrv_pkg::PH_LEN;
        end else if (log_byte == commit_type_code) begin
          if (length_accumulator != wrv_pkg::COMMIT_BODY_LEN) begin
            phase_step = wrv_pkg::PH_HALT_BADLEN;
          end else begin
            phase_step            = wrv_pkg::PH_CRC;
            field_byte_count_next = 2'd0;
            stored_crc_next       = 32'd0;
          end
        end else begin
          phase_step = wrv_pkg::PH_HALT_TYPE;
        end
      end
      wrv_pkg::PH_PAYLOAD: begin
        running_crc_next   = crc_fed;
        bytes_left_next    = left_dec;
        prim_valid         = 1'b1;
        prim.event_res     = wrv_pkg::EV_PAYLOAD;
        prim.payload_value = log_byte;
        prim.record_done   = (left_dec == 32'd0);
        if (left_dec == 32'd0) begin
          phase_step = wrv_pkg::PH_LEN;
        end
      end
      wrv_pkg::PH_CRC: begin
        stored_crc_next       = crc_merged;
        field_byte_count_next = field_byte_count + 2'd1;
        if (field_byte_count == 2'd3) begin
          if (crc_merged == ~running_crc) begin
            last_valid_end_next = position + wrv_pkg::OFFSET_BITS'(1);
            running_crc_next    = wrv_pkg::CRC_INIT;
            prim_valid          = 1'b1;
            prim.event_res      = wrv_pkg::EV_COMMIT;
            phase_step          = wrv_pkg::PH_LEN;
          end else begin
            phase_step = wrv_pkg::PH_HALT_CRC;
          end
        end
      end
      default: begin
      end
    endcase
    prim.verified_end = wrv_pkg::vend_view(last_valid_end_next);
    phase_next        = phase_step;

    // Work out the end-of-log cause from where this byte leaves the parser
    unique case (phase_step)
      wrv_pkg::PH_HALT_ZERO:   cause = wrv_pkg::CAUSE_ZERO_LEN;
      wrv_pkg::PH_HALT_BADLEN: cause = wrv_pkg::CAUSE_BAD_LEN;
      wrv_pkg::PH_HALT_CRC:    cause = wrv_pkg::CAUSE_CRC;
      wrv_pkg::PH_HALT_TYPE:   cause = wrv_pkg::CAUSE_TYPE;
      wrv_pkg::PH_LEN:
        cause = (field_byte_count_next == 2'd0) ? wrv_pkg::CAUSE_CLEAN
                                                : wrv_pkg::CAUSE_TRUNCATED;
      default:                 cause = wrv_pkg::CAUSE_TRUNCATED;
    endcase
    fin_res              = '0;
    fin_res.event_res    = wrv_pkg::EV_END;
    fin_res.verified_end = wrv_pkg::vend_view(last_valid_end_next);
    fin_res.stop_cause   = cause;
    fin_res.last_of_run  = 1'b1;

    // Final byte: start a fresh log on the next byte
    if (final_byte) begin
      phase_next              = wrv_pkg::PH_LEN;
      field_byte_count_next   = 2'd0;
      length_accumulator_next = 32'd0;
      bytes_left_next         = 32'd0;
      position_next           = '0;
      last_valid_end_next     = '0;
      running_crc_next        = wrv_pkg::CRC_INIT;
      stored_crc_next         = 32'd0;
    end

    // Pack the words for the result queue
    push = '0;
    if (accept) begin
      if (prim_valid) begin
        prim.last_of_run = !final_byte;
        push.first       = prim;
        push.second      = fin_res;
        push.count       = final_byte ? 2'd2 : 2'd1;
      end else if (final_byte) begin
        push.first = fin_res;
        push.count = 2'd1;
      end
    end
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      data_type_code   <= 8'd1;
      commit_type_code <= 8'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wrv_pkg::REG_DATA_TYPE:   data_type_code   <= cfg_data;
        wrv_pkg::REG_COMMIT_TYPE: commit_type_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= wrv_pkg::PH_LEN;
      field_byte_count   <= 2'd0;
      length_accumulator <= 32'd0;
      bytes_left         <= 32'd0;
      position           <= '0;
      last_valid_end     <= '0;
      running_crc        <= wrv_pkg::CRC_INIT;
      stored_crc         <= 32'd0;
    end else if (accept) begin
      phase              <= phase_next;
      field_byte_count   <= field_byte_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_left         <= bytes_left_next;
      position           <= position_next;
      last_valid_end     <= last_valid_end_next;
      running_crc        <= running_crc_next;
      stored_crc         <= stored_crc_next;
    end
  end

  // A final byte always leaves the parser at the start of a fresh log
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte |=> phase == wrv_pkg::PH_LEN && position == '0
      && running_crc == wrv_pkg::CRC_INIT && field_byte_count == 2'd0)
    else $error("parser not cleared after final byte");

  // A halted parser stays halted and silent until the final byte
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !final_byte && (phase == wrv_pkg::PH_HALT_ZERO
      || phase == wrv_pkg::PH_HALT_BADLEN || phase == wrv_pkg::PH_HALT_CRC
      || phase == wrv_pkg::PH_HALT_TYPE) |-> push.count == 2'd0 ##1 $stable(phase))
    else $error("halted parser moved or produced a result");

endmodule

@@ sv/wrv_out_queue.sv @@
module wrv_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  wrv_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output wrv_pkg::res_t  head
);

  wrv_pkg::res_t slots [4];
  logic [1:0]    wptr, rptr;
  logic [2:0]    count, count_next;
  logic          pop;

  assign out_valid  = (count != 3'd0);
  assign pop        = out_valid && !out_stall;
  assign room       = (count <= 3'd2);
  assign head       = slots[rptr];
  assign count_next = count + 3'(push.count) - 3'(pop);

  // Write up to two words at the tail
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wptr + 2'd1] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + push.count;
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= 3'd2)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4 && (count == 3'd0 || wptr == rptr + count[1:0]))
    else $error("result queue pointers out of step");

endmodule

@@ sv/wal_replay_validator.sv @@
// Write-ahead log replay validator. Feed the log one byte per word; the
// block answers with record starts, pass-through payload bytes, verified
// commits and one end-of-log word carrying the stop cause. It takes one log
// byte per cycle while the queue has room: the parser and its byte-wide
// CRC-32 step handle a byte combinationally and the results sit in a
// four-word queue. A byte is taken while the queue holds at most two words,
// so both words that a final byte yields always fit. Payload bytes are not
// confirmed until a commit word follows; drop them on a truncated end.
module wal_replay_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  log_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [31:0] payload_length,
  output logic [7:0]  payload_value,
  output logic        record_done,
  output logic [47:0] verified_end,
  output logic [2:0]  stop_cause,
  output logic        last_of_run
);

  wrv_pkg::push_t push;
  wrv_pkg::res_t  head;
  logic           room;
  logic           accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  wrv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .log_byte   (log_byte),
    .final_byte (final_byte),
    .push       (push)
  );

  wrv_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_res      = head.event_res;
  assign payload_length = head.payload_length;
  assign payload_value  = head.payload_value;
  assign record_done    = head.record_done;
  assign verified_end   = head.verified_end;
  assign stop_cause     = head.stop_cause;
  assign last_of_run    = head.last_of_run;

endmodule
